[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, a, c)
`define ASSERT_NEXT(lbl, clk, a, c)
`endif
`endif

[hw/rtl/ata_pio_pkg.sv]
// Types, codes and constants of the ATA PIO command sequencer.
package ata_pio_pkg;

   localparam int SECTOR_BYTES     = 512;
   localparam int MAX_PACKET_BYTES = 16;
   localparam int QUEUE_DEPTH      = 2;   // power of two
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WORD  = 2'd2;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_DATA  = 3'd2;
   localparam logic [2:0] KIND_NEED  = 3'd3;
   localparam logic [2:0] KIND_DONE  = 3'd4;

   localparam logic [3:0] REG_DATA    = 4'd0;
   localparam logic [3:0] REG_FEATURE = 4'd1;
   localparam logic [3:0] REG_COUNT   = 4'd2;
   localparam logic [3:0] REG_LBA0    = 4'd3;
   localparam logic [3:0] REG_LBA1    = 4'd4;
   localparam logic [3:0] REG_LBA2    = 4'd5;
   localparam logic [3:0] REG_DEVICE  = 4'd6;
   localparam logic [3:0] REG_STATUS  = 4'd7;
   localparam logic [3:0] REG_ALT     = 4'd14;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLAVE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLL_LIMIT = 2'd1;

   localparam logic [7:0]  DEVICE_MASK     = 8'hef;
   localparam logic [15:0] POLL_LIMIT_INIT = 16'd10000;
   localparam logic [7:0]  ST_BSY  = 8'h80;
   localparam logic [7:0]  ST_DRQ  = 8'h08;
   localparam logic [7:0]  ST_ERR  = 8'h01;
   localparam logic [1:0]  IR_CMD_OUT = 2'd1;
   localparam logic [1:0]  IR_DATA_IN = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ALT, PH_POLL, PH_STATUS1, PH_IR_CMD, PH_PKT, PH_IR_DATA,
      PH_CNT_HI, PH_CNT_LO, PH_RD, PH_WR, PH_WSTATUS, PH_CAPTURE
   } phase_type;

   typedef enum logic [2:0] {
      GO_STATUS1, GO_IR_CMD, GO_CHUNK, GO_WSTATUS, GO_CAPTURE
   } resume_type;

   typedef enum logic [1:0] {CLS_START, CLS_READ, CLS_WORD, CLS_NONE} class_type;

   typedef enum logic [1:0] {BK_POP, BK_START, BK_SECOND} back_mode_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [55:0] task_file;
      logic [31:0] high_order_file;
      logic [4:0]  packet_length;
      logic [15:0] transfer_length;
      logic        write_transfer;
      logic [15:0] read_value;
      logic [15:0] host_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  reg_address;
      logic [15:0] write_value;
      logic [15:0] data_word_out;
      logic        outcome;
      logic [15:0] bytes_moved;
      logic [55:0] final_registers;
      logic        last;
   } rsp_type;

   typedef struct packed {
      class_type cls;
      req_type   req;
   } q_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } front_status_type;

   typedef struct packed {
      logic        slave_select;
      logic [15:0] busy_poll_limit;
   } cfg_type;

endpackage

[hw/rtl/ata_pio_command_sequencer.sv]
// Top level of the ATA PIO command sequencer: control registers, intake queue, engine.
// Host-side ATA/ATAPI PIO sequencer. A start request taken while idle produces twelve
// results (device select, high-order and low-order task file writes, the command
// write, then the first alternate-status read); each device response or host word
// request taken in turn yields one or two results. The engine issues one result per
// cycle into the response register while it is not stalled. A two-entry queue lets
// requests be taken while the engine is still emitting. Drive each requested
// register read back as a response request and each need-host-word as a host word
// request. Control registers may only be written while no command is in flight.
`include "assert_macros.svh"
module ata_pio_command_sequencer
   import ata_pio_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data
);

   cfg_type          cfg_ff;
   q_item_type       q_item;
   front_status_type fstat;
   logic             pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_select    <= 1'b0;
         cfg_ff.busy_poll_limit <= POLL_LIMIT_INIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLAVE:      cfg_ff.slave_select    <= csr_data[0];
            CSR_POLL_LIMIT: cfg_ff.busy_poll_limit <= csr_data;
            default: ;
         endcase
      end
   end

   ata_pio_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pop         (pop),
      .q_item      (q_item),
      .status      (fstat)
   );

   ata_pio_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (fstat.valid),
      .q_item      (q_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_IMPLY(a_pop_needs_item, clock, reset, pop, fstat.valid)
   `ASSERT_IMPLY(a_full_is_valid, clock, reset, fstat.full, fstat.valid)
   `ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid)

endmodule

[hw/rtl/ata_pio_front.sv]
// Request intake: classifies each request and queues it for the sequencer.
module ata_pio_front
   import ata_pio_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   input  logic             pop,
   output q_item_type       q_item,
   output front_status_type status
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   q_item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   class_type           cls;

   always_comb begin
      unique case (req_payload.operation)
         OP_START: cls = CLS_START;
         OP_READ:  cls = CLS_READ;
         OP_WORD:  cls = CLS_WORD;
         default:  cls = CLS_NONE;
      endcase
   end

   assign status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign req_stall    = status.full;
   assign push         = req_valid && !req_stall;
   assign q_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cls: cls, req: req_payload};
      end
   end

endmodule

[hw/rtl/ata_pio_back.sv]
// Protocol engine: runs the command phases and drives the response register.
module ata_pio_back
   import ata_pio_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  q_item_type q_item,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   back_mode_type mode_ff, mode_in;
   logic [3:0]    seq_ff;
   phase_type     phase_ff, phase_in;
   resume_type    resume_ff, resume_in;
   logic [1:0]    alt_ff, alt_in;
   logic [3:0]    capidx_ff, capidx_in;
   logic [7:0]    ls_ff, ls_in, bch_ff, bch_in;
   logic [15:0]   bd_ff, bd_in, cl_ff, cl_in, pc_ff, pc_in;
   logic [4:0]    ps_ff, ps_in;
   logic [55:0]   cap_ff, cap_in;
   logic [15:0]   xfer_ff;
   logic [4:0]    pkt_ff;
   logic          wr_ff;
   logic [55:0]   tf_ff;
   logic [31:0]   hi_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in, second_ff, second_in;

   logic          out_free, start_go, has_pre, has_tail;
   rsp_type       pre, tail, start_rsp;
   logic [15:0]   left;
   logic [4:0]    plen;

   function automatic rsp_type mk(logic [2:0] kind, logic [3:0] addr, logic [15:0] wv,
                                  logic [15:0] dw, logic oc, logic [15:0] moved,
                                  logic [55:0] regs);
      rsp_type r;
      r.kind            = kind;
      r.reg_address     = addr;
      r.write_value     = wv;
      r.data_word_out   = dw;
      r.outcome         = oc;
      r.bytes_moved     = moved;
      r.final_registers = regs;
      r.last            = 1'b0;
      return r;
   endfunction

   function automatic rsp_type rd(logic [3:0] addr);
      return mk(KIND_READ, addr, '0, '0, 1'b0, '0, '0);
   endfunction

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = (mode_ff == BK_POP) && q_valid && out_free;
   assign start_go    = (q_item.cls == CLS_START) && (phase_ff == PH_IDLE);
   assign left        = xfer_ff - bd_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign plen        = (q_item.req.packet_length > 5'(MAX_PACKET_BYTES)) ?
                        5'(MAX_PACKET_BYTES) : q_item.req.packet_length;

   // Register writes of a start, device select through command, then first alt read.
   always_comb begin
      start_rsp = mk(KIND_WRITE, REG_DEVICE,
                     {8'h00, (tf_ff[47:40] & DEVICE_MASK) | {3'b000, cfg.slave_select, 4'h0}},
                     '0, 1'b0, '0, '0);
      case (seq_ff)
         4'd1:  start_rsp.write_value = {8'h00, hi_ff[7:0]};
         4'd2:  start_rsp.write_value = {8'h00, hi_ff[15:8]};
         4'd3:  start_rsp.write_value = {8'h00, hi_ff[23:16]};
         4'd4:  start_rsp.write_value = {8'h00, hi_ff[31:24]};
         4'd5:  start_rsp.write_value = {8'h00, tf_ff[7:0]};
         4'd6:  start_rsp.write_value = {8'h00, tf_ff[15:8]};
         4'd7:  start_rsp.write_value = {8'h00, tf_ff[23:16]};
         4'd8:  start_rsp.write_value = {8'h00, tf_ff[31:24]};
         4'd9:  start_rsp.write_value = {8'h00, tf_ff[39:32]};
         4'd10: start_rsp.write_value = {8'h00, tf_ff[55:48]};
         default: ;
      endcase
      case (seq_ff)
         4'd1, 4'd2, 4'd3, 4'd4: start_rsp.reg_address = REG_COUNT + (seq_ff - 4'd1);
         4'd5, 4'd6, 4'd7, 4'd8, 4'd9:
            start_rsp.reg_address = REG_FEATURE + (seq_ff - 4'd5);
         4'd10: start_rsp.reg_address = REG_STATUS;
         4'd11: start_rsp = rd(REG_ALT);
         default: ;
      endcase
      start_rsp.last = (seq_ff == 4'd11);
   end

   // One response or host word: state update plus up to two results.
   always_comb begin
      logic [7:0]  b;
      logic [15:0] cnt, take, dev_cnt;
      logic        want_bc, want_nd, want_lc;
      resume_type  go;
      phase_in  = phase_ff;
      resume_in = resume_ff;
      alt_in    = alt_ff;
      capidx_in = capidx_ff;
      ls_in     = ls_ff;
      bch_in    = bch_ff;
      bd_in     = bd_ff;
      cl_in     = cl_ff;
      pc_in     = pc_ff;
      ps_in     = ps_ff;
      cap_in    = cap_ff;
      has_pre   = 1'b0;
      has_tail  = 1'b0;
      pre       = '0;
      tail      = '0;
      want_bc   = 1'b0;
      want_nd   = 1'b0;
      want_lc   = 1'b0;
      go        = GO_STATUS1;
      cnt       = 16'(SECTOR_BYTES);
      take      = '0;
      b         = q_item.req.read_value[7:0];
      dev_cnt   = {bch_ff, b};
      case (q_item.cls)
         CLS_READ: begin
            case (phase_ff)
               PH_ALT: begin
                  has_tail = 1'b1;
                  alt_in   = alt_ff + 2'd1;
                  if (alt_ff != 2'd3) begin
                     tail = rd(REG_ALT);
                  end else begin
                     pc_in    = '0;
                     tail     = rd(REG_STATUS);
                     phase_in = PH_POLL;
                  end
               end
               PH_POLL: begin
                  if ((b & ST_BSY) != '0 &&
                      (cfg.busy_poll_limit == '0 || pc_ff < cfg.busy_poll_limit)) begin
                     pc_in    = pc_ff + 16'd1;
                     tail     = rd(REG_STATUS);
                     has_tail = 1'b1;
                  end else begin
                     has_tail = 1'b1;
                     case (resume_ff)
                        GO_STATUS1: begin
                           tail = rd(REG_STATUS); phase_in = PH_STATUS1;
                        end
                        GO_IR_CMD: begin
                           tail = rd(REG_COUNT); phase_in = PH_IR_CMD;
                        end
                        GO_CHUNK: begin
                           if (pkt_ff != '0) begin
                              tail = rd(REG_COUNT); phase_in = PH_IR_DATA;
                           end else begin
                              has_tail = 1'b0; want_bc = 1'b1;
                           end
                        end
                        GO_WSTATUS: begin
                           tail = rd(REG_STATUS); phase_in = PH_WSTATUS;
                        end
                        default: begin
                           capidx_in = 4'd1;
                           tail      = rd(REG_FEATURE);
                           phase_in  = PH_CAPTURE;
                        end
                     endcase
                  end
               end
               PH_STATUS1: begin
                  ls_in = b;
                  if (pkt_ff != '0) begin
                     has_tail = 1'b1; tail = rd(REG_ALT); phase_in = PH_ALT;
                     resume_in = GO_IR_CMD; alt_in = '0;
                  end else begin
                     want_lc = 1'b1;
                  end
               end
               PH_IR_CMD: begin
                  if ((ls_ff & ST_DRQ) == '0 || b[1:0] != IR_CMD_OUT) begin
                     has_tail = 1'b1; phase_in = PH_IDLE;
                     tail = mk(KIND_DONE, '0, '0, '0, 1'b1, bd_ff, cap_ff);
                  end else begin
                     ps_in = '0;
                     if (pkt_ff >= 5'd2) begin
                        has_tail = 1'b1; phase_in = PH_PKT;
                        tail = mk(KIND_NEED, '0, '0, '0, 1'b0, '0, '0);
                     end else begin
                        want_lc = 1'b1;
                     end
                  end
               end
               PH_IR_DATA: begin
                  has_tail = 1'b1;
                  if (b[1:0] != IR_DATA_IN) begin
                     phase_in = PH_IDLE;
                     tail = mk(KIND_DONE, '0, '0, '0, 1'b1, bd_ff, cap_ff);
                  end else begin
                     tail = rd(REG_LBA2); phase_in = PH_CNT_HI;
                  end
               end
               PH_CNT_HI: begin
                  bch_in = b; has_tail = 1'b1;
                  tail = rd(REG_LBA1); phase_in = PH_CNT_LO;
               end
               PH_CNT_LO: begin
                  // odd byte count is allowed only for the final chunk
                  if (dev_cnt == '0 || dev_cnt > left || (dev_cnt[0] && dev_cnt != left)) begin
                     has_tail = 1'b1; phase_in = PH_IDLE;
                     tail = mk(KIND_DONE, '0, '0, '0, 1'b1, bd_ff, cap_ff);
                  end else begin
                     cnt = dev_cnt; want_bc = 1'b1;
                  end
               end
               PH_RD: begin
                  has_pre = 1'b1;
                  pre     = mk(KIND_DATA, '0, '0, q_item.req.read_value, 1'b0, '0, '0);
                  cl_in   = cl_ff - 16'd2;
                  want_nd = 1'b1;
               end
               PH_WSTATUS: begin
                  ls_in = b; has_tail = 1'b1;
                  if ((b & (ST_DRQ | ST_ERR)) != '0) begin
                     phase_in = PH_IDLE;
                     tail = mk(KIND_DONE, '0, '0, '0, 1'b1, bd_ff, cap_ff);
                  end else begin
                     tail = rd(REG_ALT); phase_in = PH_ALT;
                     resume_in = GO_CAPTURE; alt_in = '0;
                  end
               end
               PH_CAPTURE: begin
                  case (3'(capidx_ff - 4'd1))
                     3'd0: cap_in[7:0]   = cap_ff[7:0]   | b;
                     3'd1: cap_in[15:8]  = cap_ff[15:8]  | b;
                     3'd2: cap_in[23:16] = cap_ff[23:16] | b;
                     3'd3: cap_in[31:24] = cap_ff[31:24] | b;
                     3'd4: cap_in[39:32] = cap_ff[39:32] | b;
                     3'd5: cap_in[47:40] = cap_ff[47:40] | b;
                     3'd6: cap_in[55:48] = cap_ff[55:48] | b;
                     default: ;
                  endcase
                  capidx_in = capidx_ff + 4'd1;
                  has_tail  = 1'b1;
                  if (capidx_in <= 4'd7) begin
                     tail = rd(capidx_in);
                  end else begin
                     ls_in    = b;
                     phase_in = PH_IDLE;
                     tail = mk(KIND_DONE, '0, '0, '0, (b & (ST_DRQ | ST_ERR)) != '0,
                               bd_ff, cap_in);
                  end
               end
               default: ;
            endcase
         end
         CLS_WORD: begin
            if (phase_ff == PH_PKT) begin
               has_pre = 1'b1;
               pre = mk(KIND_WRITE, REG_DATA, q_item.req.host_word, '0, 1'b0, '0, '0);
               ps_in = ps_ff + 5'd2;
               if ({1'b0, ps_in} + 6'd2 <= {1'b0, pkt_ff}) begin
                  has_tail = 1'b1;
                  tail = mk(KIND_NEED, '0, '0, '0, 1'b0, '0, '0);
               end else begin
                  want_lc = 1'b1;
               end
            end else if (phase_ff == PH_WR) begin
               has_pre = 1'b1;
               pre = mk(KIND_WRITE, REG_DATA, q_item.req.host_word, '0, 1'b0, '0, '0);
               cl_in   = cl_ff - 16'd2;
               want_nd = 1'b1;
            end
         end
         default: ;
      endcase

      if (want_bc) begin
         take    = (cnt > left) ? left : cnt;
         bd_in   = bd_ff + take;
         cl_in   = {take[15:1], 1'b0};
         want_nd = 1'b1;
      end
      if (want_nd) begin
         if (cl_in >= 16'd2) begin
            has_tail = 1'b1;
            if (wr_ff) begin
               tail = mk(KIND_NEED, '0, '0, '0, 1'b0, '0, '0); phase_in = PH_WR;
            end else begin
               tail = rd(REG_DATA); phase_in = PH_RD;
            end
         end else begin
            want_lc = 1'b1;
         end
      end
      if (want_lc) begin
         if (bd_in < xfer_ff && (ls_in & (ST_DRQ | ST_ERR)) == ST_DRQ) go = GO_CHUNK;
         else if (wr_ff) go = GO_WSTATUS;
         else go = GO_CAPTURE;
         has_tail  = 1'b1;
         tail      = rd(REG_ALT);
         phase_in  = PH_ALT;
         resume_in = go;
         alt_in    = '0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         BK_POP: begin
            if (pop && start_go) mode_in = BK_START;
            else if (pop && has_pre) mode_in = BK_SECOND;
         end
         BK_START: begin
            if (out_free && seq_ff == 4'd11) mode_in = BK_POP;
         end
         BK_SECOND: begin
            if (out_free) mode_in = BK_POP;
         end
         default: mode_in = BK_POP;
      endcase
   end

   // Response register: held while stalled, loaded from the start sequence, the
   // second result of a pair, or the result of a popped request.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      second_in    = second_ff;
      if (mode_ff == BK_START && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = start_rsp;
      end
      if (mode_ff == BK_SECOND && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = second_ff;
      end
      if (pop && q_item.cls != CLS_START && has_tail) begin
         rsp_valid_in = 1'b1;
         if (has_pre) begin
            rsp_in         = pre;
            second_in      = tail;
            second_in.last = 1'b1;
         end else begin
            rsp_in      = tail;
            rsp_in.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= BK_POP;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         resume_ff    <= GO_STATUS1;
         alt_ff       <= '0;
         capidx_ff    <= '0;
         ls_ff        <= '0;
         bch_ff       <= '0;
         bd_ff        <= '0;
         cl_ff        <= '0;
         pc_ff        <= '0;
         ps_ff        <= '0;
         cap_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mode_ff == BK_START && out_free) begin
            seq_ff <= seq_ff + 4'd1;
         end
         if (pop && q_item.cls == CLS_START) begin
            if (start_go) begin
               seq_ff    <= '0;
               phase_ff  <= PH_ALT;
               resume_ff <= GO_STATUS1;
               alt_ff    <= '0;
               ls_ff     <= '0;
               bch_ff    <= '0;
               bd_ff     <= '0;
               cl_ff     <= '0;
               pc_ff     <= '0;
               ps_ff     <= '0;
               cap_ff    <= '0;
            end
         end else if (pop) begin
            phase_ff  <= phase_in;
            resume_ff <= resume_in;
            alt_ff    <= alt_in;
            capidx_ff <= capidx_in;
            ls_ff     <= ls_in;
            bch_ff    <= bch_in;
            bd_ff     <= bd_in;
            cl_ff     <= cl_in;
            pc_ff     <= pc_in;
            ps_ff     <= ps_in;
            cap_ff    <= cap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && start_go) begin
         xfer_ff <= q_item.req.transfer_length;
         pkt_ff  <= plen;
         wr_ff   <= q_item.req.write_transfer;
         tf_ff   <= q_item.req.task_file;
         hi_ff   <= q_item.req.high_order_file;
      end
      rsp_ff    <= rsp_in;
      second_ff <= second_in;
   end

endmodule

[dv/tb_ata_pio_command_sequencer.sv]
// Self-checking testbench for the ATA PIO command sequencer.
`timescale 1ns / 1ps
module tb_ata_pio_command_sequencer;
   import ata_pio_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 80;

   // Expected-response tracker with its own copy of the sequencer state.
   class sequencer_scoreboard;
      rsp_type     expected_q[$];
      int          errors;
      int          checked;
      int          commands;
      logic        slave;
      logic [15:0] poll_limit;
      phase_type   phase;
      resume_type  resume;
      logic [7:0]  status, count_high;
      logic [15:0] moved, chunk, xfer, polls;
      logic [4:0]  pkt_len, pkt_sent;
      logic        writing;
      int          alt_n, cap_i;
      logic [55:0] captured;

      function new();
         slave = 1'b0;
         poll_limit = POLL_LIMIT_INIT;
         phase = PH_IDLE;
         resume = GO_STATUS1;
      endfunction

      function void put(logic [2:0] kind, logic [3:0] addr, logic [15:0] wv,
                        logic [15:0] dw, logic oc, logic [15:0] mv, logic [55:0] regs);
         rsp_type r;
         r = '{kind, addr, wv, dw, oc, mv, regs, 1'b0};
         expected_q.push_back(r);
      endfunction

      function void rd(logic [3:0] addr, phase_type nxt);
         put(KIND_READ, addr, '0, '0, 1'b0, '0, '0);
         phase = nxt;
      endfunction

      function void finish_cmd(logic oc);
         put(KIND_DONE, '0, '0, '0, oc, moved, captured);
         phase = PH_IDLE;
      endfunction

      function void start_wait(resume_type go);
         resume = go;
         alt_n = 0;
         rd(REG_ALT, PH_ALT);
      endfunction

      function void loop_check();
         if (moved < xfer && (status & (ST_DRQ | ST_ERR)) == ST_DRQ) start_wait(GO_CHUNK);
         else if (writing) start_wait(GO_WSTATUS);
         else start_wait(GO_CAPTURE);
      endfunction

      function void next_data();
         if (chunk >= 16'd2) begin
            if (writing) begin
               put(KIND_NEED, '0, '0, '0, 1'b0, '0, '0);
               phase = PH_WR;
            end else begin
               rd(REG_DATA, PH_RD);
            end
         end else begin
            loop_check();
         end
      endfunction

      function void begin_chunk(logic [15:0] cnt);
         logic [15:0] left;
         left = xfer - moved;
         if (cnt > left) cnt = left;
         moved = moved + cnt;
         chunk = cnt & 16'hfffe;
         next_data();
      endfunction

      function void next_packet();
         if (pkt_sent + 6'd2 <= pkt_len) begin
            put(KIND_NEED, '0, '0, '0, 1'b0, '0, '0);
            phase = PH_PKT;
         end else begin
            loop_check();
         end
      endfunction

      function void wait_done();
         case (resume)
            GO_STATUS1: rd(REG_STATUS, PH_STATUS1);
            GO_IR_CMD: rd(REG_COUNT, PH_IR_CMD);
            GO_CHUNK: begin
               if (pkt_len != '0) rd(REG_COUNT, PH_IR_DATA);
               else begin_chunk(16'(SECTOR_BYTES));
            end
            GO_WSTATUS: rd(REG_STATUS, PH_WSTATUS);
            default: begin
               cap_i = 1;
               rd(REG_FEATURE, PH_CAPTURE);
            end
         endcase
      endfunction

      function void on_read(logic [15:0] v);
         logic [7:0]  b;
         logic [15:0] cnt, left;
         b = v[7:0];
         case (phase)
            PH_ALT: begin
               alt_n++;
               if (alt_n < 4) rd(REG_ALT, PH_ALT);
               else begin
                  polls = '0;
                  rd(REG_STATUS, PH_POLL);
               end
            end
            PH_POLL: begin
               if ((b & ST_BSY) != '0 && (poll_limit == '0 || polls < poll_limit)) begin
                  polls = polls + 16'd1;
                  rd(REG_STATUS, PH_POLL);
               end else begin
                  wait_done();
               end
            end
            PH_STATUS1: begin
               status = b;
               if (pkt_len != '0) start_wait(GO_IR_CMD);
               else loop_check();
            end
            PH_IR_CMD: begin
               if ((status & ST_DRQ) == '0 || b[1:0] != IR_CMD_OUT) finish_cmd(1'b1);
               else begin
                  pkt_sent = '0;
                  next_packet();
               end
            end
            PH_IR_DATA: begin
               if (b[1:0] != IR_DATA_IN) finish_cmd(1'b1);
               else rd(REG_LBA2, PH_CNT_HI);
            end
            PH_CNT_HI: begin
               count_high = b;
               rd(REG_LBA1, PH_CNT_LO);
            end
            PH_CNT_LO: begin
               cnt = {count_high, b};
               left = xfer - moved;
               if (!(cnt > 16'd0 && cnt <= left && (cnt[0] == 1'b0 || cnt == left)))
                  finish_cmd(1'b1);
               else begin_chunk(cnt);
            end
            PH_RD: begin
               put(KIND_DATA, '0, '0, v, 1'b0, '0, '0);
               chunk = chunk - 16'd2;
               next_data();
            end
            PH_WSTATUS: begin
               status = b;
               if ((b & (ST_DRQ | ST_ERR)) != '0) finish_cmd(1'b1);
               else start_wait(GO_CAPTURE);
            end
            PH_CAPTURE: begin
               captured = captured | (56'(b) << (8 * ((cap_i - 1) & 7)));
               cap_i++;
               if (cap_i <= 7) rd(4'(cap_i), PH_CAPTURE);
               else begin
                  status = b;
                  finish_cmd((b & (ST_DRQ | ST_ERR)) != '0);
               end
            end
            default: ;
         endcase
      endfunction

      function void on_start(req_type r);
         pkt_len = (r.packet_length > 5'(MAX_PACKET_BYTES)) ? 5'(MAX_PACKET_BYTES)
                                                             : r.packet_length;
         xfer = r.transfer_length;
         writing = r.write_transfer;
         status = '0;
         count_high = '0;
         moved = '0;
         chunk = '0;
         pkt_sent = '0;
         polls = '0;
         captured = '0;
         commands++;
         put(KIND_WRITE, REG_DEVICE,
             {8'h0, (r.task_file[47:40] & DEVICE_MASK) | {3'b0, slave, 4'b0}},
             '0, 1'b0, '0, '0);
         for (int i = 0; i < 4; i++)
            put(KIND_WRITE, REG_COUNT + 4'(i), {8'h0, r.high_order_file[8*i +: 8]},
                '0, 1'b0, '0, '0);
         for (int i = 0; i < 5; i++)
            put(KIND_WRITE, REG_FEATURE + 4'(i), {8'h0, r.task_file[8*i +: 8]},
                '0, 1'b0, '0, '0);
         put(KIND_WRITE, REG_STATUS, {8'h0, r.task_file[55:48]}, '0, 1'b0, '0, '0);
         start_wait(GO_STATUS1);
      endfunction

      function void note_request(req_type r);
         int prior_size;
         prior_size = expected_q.size();
         case (r.operation)
            OP_START: if (phase == PH_IDLE) on_start(r);
            OP_READ: on_read(r.read_value);
            OP_WORD: begin
               if (phase == PH_PKT) begin
                  put(KIND_WRITE, REG_DATA, r.host_word, '0, 1'b0, '0, '0);
                  pkt_sent = pkt_sent + 5'd2;
                  next_packet();
               end else if (phase == PH_WR) begin
                  put(KIND_WRITE, REG_DATA, r.host_word, '0, 1'b0, '0, '0);
                  chunk = chunk - 16'd2;
                  next_data();
               end
            end
            default: ;
         endcase
         if (expected_q.size() > prior_size) expected_q[expected_q.size() - 1].last = 1'b1;
      endfunction

      function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(rsp_type act);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected response, kind %0d", act.kind);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare("kind", 64'(e.kind), 64'(act.kind));
         compare("reg_address", 64'(e.reg_address), 64'(act.reg_address));
         compare("write_value", 64'(e.write_value), 64'(act.write_value));
         compare("data_word_out", 64'(e.data_word_out), 64'(act.data_word_out));
         compare("outcome", 64'(e.outcome), 64'(act.outcome));
         compare("bytes_moved", 64'(e.bytes_moved), 64'(act.bytes_moved));
         compare("final_registers", 64'(e.final_registers), 64'(act.final_registers));
         compare("last", 64'(e.last), 64'(act.last));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   rsp_type rsp_payload;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   sequencer_scoreboard sb = new();
   int cycles = 0;
   int items = 0;
   logic calm = 0;
   logic long_hold = 0;
   logic no_drq = 0;
   logic [15:0] planned_count;

   ata_pio_command_sequencer dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);

   // Response side: random back-pressure, one long hold-off when asked.
   initial begin
      int k;
      while (reset) @(posedge clock);
      forever begin
         k = calm ? 0 : $urandom_range(0, 17);
         if (long_hold) begin
            k = 400;
            long_hold = 0;
         end
         if (k > 0) begin
            rsp_stall <= 1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [15:0] device_answer();
      logic [7:0] b, hi;
      logic [15:0] left;
      b = 8'($urandom);
      hi = 8'($urandom);
      case (sb.phase)
         PH_POLL: if ($urandom_range(0, 3) != 0) b[7] = 1'b0;
         PH_STATUS1: if ($urandom_range(0, 7) != 0) b = (b & ~(ST_ERR | ST_BSY)) | ST_DRQ;
         PH_IR_CMD: if ($urandom_range(0, 7) != 0) b[1:0] = IR_CMD_OUT;
         PH_IR_DATA: if ($urandom_range(0, 7) != 0) b[1:0] = IR_DATA_IN;
         PH_CNT_HI: begin
            left = sb.xfer - sb.moved;
            if ($urandom_range(0, 9) == 0) planned_count = 16'($urandom);
            else begin
               planned_count = 16'($urandom_range(1, left));
               if (planned_count[0] && planned_count != left) planned_count++;
            end
            b = planned_count[15:8];
         end
         PH_CNT_LO: b = planned_count[7:0];
         PH_WSTATUS: if ($urandom_range(0, 5) != 0) b = b & ~(ST_DRQ | ST_ERR);
         PH_CAPTURE: if (sb.cap_i == 7 && $urandom_range(0, 5) != 0) b = b & ~(ST_DRQ | ST_ERR);
         default: ;
      endcase
      if (sb.phase == PH_STATUS1 && no_drq) b = b & ~ST_DRQ;
      return {hi, b};
   endfunction

   function automatic req_type random_start();
      req_type r;
      r = '0;
      r.operation = OP_START;
      r.task_file = 56'({$urandom, $urandom});
      r.high_order_file = $urandom;
      r.packet_length = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(1, 31));
      r.transfer_length = 16'($urandom_range(0, 24));
      r.write_transfer = 1'($urandom_range(0, 1));
      r.read_value = 16'($urandom);
      r.host_word = 16'($urandom);
      return r;
   endfunction

   function automatic req_type build_item();
      req_type r;
      r = random_start();
      r.task_file = 56'({$urandom, $urandom});
      if ($urandom_range(0, 11) == 0) begin
         // noise: anything, including unused codes and out-of-turn requests
         r.operation = 2'($urandom_range(0, 3));
      end else if (sb.phase == PH_IDLE) begin
         r.operation = OP_START;
         no_drq = 0;
      end else if (sb.phase == PH_PKT || sb.phase == PH_WR) begin
         r.operation = OP_WORD;
      end else begin
         r.operation = OP_READ;
         r.read_value = device_answer();
      end
      return r;
   endfunction

   task automatic send(req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      items++;
   endtask

   task automatic settle();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SLAVE) sb.slave = val[0];
      else sb.poll_limit = val;
      csr_valid <= 0;
   endtask

   // Drive one command to completion, answering every access the block makes.
   task automatic run_command(req_type first);
      send(first);
      while (sb.phase != PH_IDLE) send(build_item());
   endtask

   initial begin
      req_type d;
      logic [15:0] limits[5] = '{16'd10000, 16'd0, 16'd2, 16'd65535, 16'd1};
      int target;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed commands: field extremes, clamped and odd packets, odd chunk
      d = random_start();
      d.task_file = '1; d.high_order_file = '1; d.packet_length = 5'd0;
      d.transfer_length = 16'd4; d.write_transfer = 1'b0;
      run_command(d);
      d = random_start();
      no_drq = 1;
      d.packet_length = 5'd31; d.transfer_length = 16'hffff; d.write_transfer = 1'b1;
      run_command(d);
      no_drq = 0;
      d = random_start();
      d.task_file = '0; d.high_order_file = '0; d.packet_length = 5'd13;
      d.transfer_length = 16'd7; d.write_transfer = 1'b0;
      run_command(d);
      d = random_start();
      d.packet_length = 5'd12; d.transfer_length = 16'd6; d.write_transfer = 1'b1;
      run_command(d);
      d = random_start();
      d.packet_length = 5'd0; d.transfer_length = 16'd3; d.write_transfer = 1'b1;
      run_command(d);

      for (int p = 0; p < 5; p++) begin
         settle();
         csr_write(CSR_SLAVE, 16'(p & 1));
         csr_write(CSR_POLL_LIMIT, limits[p]);
         target = items + RANDOM_ITEMS / 5;
         while (items < target) begin
            calm = ($urandom_range(0, 4) == 0);
            if (p == 2 && items + 20 > target) begin
               // sender offers while the response side holds off
               long_hold = 1;
               calm = 1;
            end
            run_command(random_start());
            if (p == 1) settle();
         end
         calm = 0;
      end

      settle();
      $display("Ran %0d commands, %0d requests, %0d responses checked, %0d errors.",
               sb.commands, items, sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ata_pio_pkg.sv
hw/rtl/ata_pio_front.sv
hw/rtl/ata_pio_back.sv
hw/rtl/ata_pio_command_sequencer.sv
dv/tb_ata_pio_command_sequencer.sv
